>>> hw/rtl/firrb_pkg.sv
// Shared types and constants for the ring-buffer FIR filter.
`timescale 1ns / 1ps
package firrb_pkg;

  localparam int DATA_W      = 16;   // sample and coefficient width
  localparam int ACC_W       = 32;   // wrapping accumulator width
  localparam int OUT_SHIFT   = 16;   // arithmetic shift applied to the sum
  localparam int DIGIT_W     = 4;    // coefficient bits consumed per cycle
  localparam int DIGIT_LOG   = 2;    // log2 of DIGIT_W
  localparam int NUM_DIGITS  = DATA_W / DIGIT_W;
  localparam int DIG_SEL_W   = 2;    // digit counter width
  localparam int COEF_IDX_W  = 6;
  localparam int TAP_COUNT_W = 7;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [DIG_SEL_W-1:0]   DIG_FIRST     = '0;
  localparam logic [DIG_SEL_W-1:0]   DIG_LAST      = DIG_SEL_W'(NUM_DIGITS - 1);
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd64;

  // register index taken from paddr[2]
  localparam logic REG_TAP_COUNT = 1'b0;

  // action field codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIME,
    ST_MAC,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic                 clr;   // zero the accumulator
    logic                 en;    // process one coefficient digit
    logic [DIG_SEL_W-1:0] dig;   // which digit of the coefficient
  } mac_ctl_t;

endpackage

>>> hw/rtl/firrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module firrb_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/firrb_mac.sv
// Digit-serial multiply-accumulate: one 4-bit coefficient digit per cycle.
`timescale 1ns / 1ps
module firrb_mac
  import firrb_pkg::*;
(
  input  logic              clk_i,
  input  mac_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] sample_i,   // ring read data, valid at digit 0
  input  logic [DATA_W-1:0] coef_i,     // coefficient read data, valid at digit 0
  output logic [ACC_W-1:0]  acc_o
);

  logic [DATA_W-1:0]         smp_q, smp_d;
  logic [DATA_W-DIGIT_W-1:0] csh_q, csh_d;
  logic [ACC_W-1:0]          acc_q, acc_d;

  logic [DATA_W-1:0]                smp;
  logic signed [DIGIT_W:0]          dval;
  logic signed [DATA_W+DIGIT_W:0]   pp;
  logic [ACC_W-1:0]                 pp_ext;
  logic [DIG_SEL_W+DIGIT_LOG-1:0]   shamt;

  always_comb begin
    if (ctl_i.dig == DIG_FIRST) begin
      smp   = sample_i;
      dval  = {1'b0, coef_i[DIGIT_W-1:0]};
      csh_d = coef_i[DATA_W-1:DIGIT_W];
    end else begin
      smp   = smp_q;
      csh_d = csh_q >> DIGIT_W;
      // top digit carries the coefficient sign
      if (ctl_i.dig == DIG_LAST) begin
        dval = {csh_q[DIGIT_W-1], csh_q[DIGIT_W-1:0]};
      end else begin
        dval = {1'b0, csh_q[DIGIT_W-1:0]};
      end
    end
    pp     = $signed(smp) * dval;
    pp_ext = ACC_W'(pp);
    shamt  = {ctl_i.dig, {DIGIT_LOG{1'b0}}};
    smp_d  = smp;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.en) begin
      acc_d = acc_q + (pp_ext << shamt);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.en) begin
      smp_q <= smp_d;
      csh_q <= csh_d;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> hw/rtl/fir_filter_ring_buffer_top.sv
// Top level of the ring-buffer FIR filter: sequencer, memories, MAC and config port.
`timescale 1ns / 1ps
// A load word (action 0) writes one coefficient. A sample word (action 1) is written
// into the sample ring and then filtered over n taps, n being tap_count clamped to
// 1..MAX_TAPS. The digit-serial MAC consumes one 4-bit coefficient digit per cycle,
// after a memory-read prime state and before a result state that waits while an
// earlier result is still unread; no new word is taken until the sample is done.
// The result sits in an output register, so a new word is accepted while a finished
// one waits. After reset a clearing pass zeroes the sample ring, during which no
// word is accepted; configuration writes are taken at any time. Coefficients must
// be loaded before they are used.
module fir_filter_ring_buffer_top
  import firrb_pkg::*;
#(
  parameter int MAX_TAPS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [COEF_IDX_W-1:0]    coef_index_i,
  input  logic signed [DATA_W-1:0] coef_value_i,
  input  logic signed [DATA_W-1:0] sample_in_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] filtered_out_o
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int CW = (NW > TAP_COUNT_W) ? NW : TAP_COUNT_W;
  localparam int KW = (NW > COEF_IDX_W) ? NW : COEF_IDX_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_TAPS - 1);

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          tap_q, tap_d;
  logic [NW-1:0]          n_q, n_d;
  logic                   last_q, last_d;
  logic [DIG_SEL_W-1:0]   dig_q, dig_d;
  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      out_q, out_d;
  logic [TAP_COUNT_W-1:0] tap_count_q, tap_count_d;

  logic [CW-1:0]     tc_ext;
  logic [NW-1:0]     n_cur;
  logic [AW-1:0]     ptr;
  logic [NW-1:0]     wp_inc;
  logic [AW-1:0]     wp_next;
  logic [NW-1:0]     pos_inc;
  logic [AW-1:0]     pos_adv;
  logic              coef_ok;
  logic              cfg_wr;

  logic              ring_we;
  logic [AW-1:0]     ring_waddr;
  logic [DATA_W-1:0] ring_wdata;
  logic [DATA_W-1:0] ring_rdata;
  logic              coef_we;
  logic [DATA_W-1:0] coef_rdata;
  logic [ACC_W-1:0]  acc;
  mac_ctl_t          mac_ctl;

  // ---------------------------------------------------------------------------
  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT);
  assign tap_count_d = cfg_wr ? pwdata[TAP_COUNT_W-1:0] : tap_count_q;
  assign prdata = (paddr[2] == REG_TAP_COUNT) ? PDATA_W'(tap_count_q) : '0;

  // taps in use: zero acts as one, large values saturate
  always_comb begin
    tc_ext = CW'(tap_count_q);
    if (tc_ext == '0) begin
      n_cur = NW'(1);
    end else if (tc_ext > CW'(MAX_TAPS)) begin
      n_cur = NW'(MAX_TAPS);
    end else begin
      n_cur = NW'(tc_ext);
    end
  end

  assign ptr     = (NW'(wp_q) >= n_cur) ? '0 : wp_q;
  assign wp_inc  = NW'(ptr) + NW'(1);
  assign wp_next = (wp_inc == n_cur) ? '0 : AW'(wp_inc);
  assign pos_inc = NW'(pos_q) + NW'(1);
  assign pos_adv = (pos_inc == n_q) ? '0 : AW'(pos_inc);
  assign coef_ok = KW'(coef_index_i) < KW'(MAX_TAPS);

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wp_d        = wp_q;
    pos_d       = pos_q;
    tap_d       = tap_q;
    n_d         = n_q;
    last_d      = last_q;
    dig_d       = dig_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ring_we     = 1'b0;
    ring_waddr  = clr_q;
    ring_wdata  = '0;
    coef_we     = 1'b0;
    mac_ctl     = '{clr: 1'b0, en: 1'b0, dig: dig_q};

    unique case (state_q)
      ST_CLEAR: begin
        ring_we = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            coef_we = coef_ok;
          end else begin
            ring_we     = 1'b1;
            ring_waddr  = ptr;
            ring_wdata  = sample_in_i;
            wp_d        = wp_next;
            pos_d       = wp_next;   // oldest sample sits right after the newest
            tap_d       = '0;
            n_d         = n_cur;
            mac_ctl.clr = 1'b1;
            state_d     = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        dig_d   = DIG_FIRST;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mac_ctl.en = 1'b1;
        dig_d      = dig_q + DIG_SEL_W'(1);
        // read data is consumed at the first digit, so the next tap's read can start
        if (dig_q == DIG_FIRST) begin
          last_d = (NW'(tap_q) == (n_q - NW'(1)));
          pos_d  = pos_adv;
          tap_d  = tap_q + AW'(1);
        end
        if (dig_q == DIG_LAST && last_q) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = acc[OUT_SHIFT +: DATA_W];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      pos_q       <= '0;
      tap_q       <= '0;
      n_q         <= NW'(1);
      last_q      <= 1'b0;
      dig_q       <= DIG_FIRST;
      out_valid_q <= 1'b0;
      tap_count_q <= TAP_COUNT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      pos_q       <= pos_d;
      tap_q       <= tap_d;
      n_q         <= n_d;
      last_q      <= last_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
      tap_count_q <= tap_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_q;

  // ---------------------------------------------------------------------------
  // storage and datapath
  firrb_ram #(
    .Width(DATA_W),
    .Depth(MAX_TAPS)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .raddr_i(pos_q),
    .rdata_o(ring_rdata)
  );

  firrb_ram #(
    .Width(DATA_W),
    .Depth(MAX_TAPS)
  ) u_coef (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(AW'(coef_index_i)),
    .wdata_i(coef_value_i),
    .raddr_i(tap_q),
    .rdata_o(coef_rdata)
  );

  firrb_mac u_mac (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .sample_i(ring_rdata),
    .coef_i  (coef_rdata),
    .acc_o   (acc)
  );

`ifndef NO_ASSERTIONS
  a_sample_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_SAMPLE) |=> state_q == ST_PRIME)
    else $error("sample word did not start a filter run");

  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRIME) |-> (NW'(wp_q) < n_q))
    else $error("write pointer outside the active ring");

  a_pos_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (NW'(pos_q) < n_q))
    else $error("read position outside the active ring");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && out_valid_q && !out_ready_i) |=> state_q == ST_HOLD)
    else $error("pending result overwritten");
`endif

endmodule
